### src/ffrd_pkg.sv
`timescale 1ns / 1ps

package ffrd_pkg;

    localparam int FRAME_LENGTH  = 29;
    localparam int PAYLOAD_FIRST = 2;
    localparam int PAYLOAD_COUNT = 26;
    localparam int NUM_BANKS     = 2;

    localparam int POS_W  = $clog2(FRAME_LENGTH + 1);
    localparam int LANE_W = $clog2(PAYLOAD_COUNT);
    localparam int BANK_W = $clog2(NUM_BANKS);
    localparam int TALLY_W = 16;

    localparam logic [7:0] START_BYTE_RESET = 8'hAF;
    localparam logic [7:0] TYPE_BYTE_RESET  = 8'h01;
    localparam logic [7:0] END_BYTE_RESET   = 8'hFA;

    typedef enum logic [1:0] {
        CMD_BYTE     = 2'd0,
        CMD_LINE_ERR = 2'd1,
        CMD_POLL     = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_START = 2'd0,
        REG_TYPE  = 2'd1,
        REG_END   = 2'd2
    } reg_idx_t;

    typedef logic [PAYLOAD_COUNT-1:0][7:0] payload_t;

    typedef struct packed {
        logic              en;
        logic [BANK_W-1:0] bank;
        logic [LANE_W-1:0] lane;
        logic [7:0]        data;
    } mem_wr_t;

    typedef struct packed {
        logic              en;
        logic [BANK_W-1:0] bank;
    } mem_rd_t;

endpackage

### src/ffrd_payload_mem.sv
`timescale 1ns / 1ps

module ffrd_payload_mem (
    input  logic              clk,
    input  ffrd_pkg::mem_wr_t wr,
    input  ffrd_pkg::mem_rd_t rd,
    output ffrd_pkg::payload_t rd_data
);
    import ffrd_pkg::*;

    // one row per bank, byte-lane writes, whole-row registered read
    payload_t mem_array [NUM_BANKS];
    payload_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_array[wr.bank][wr.lane] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem_array[rd.bank];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/fixed_frame_receiver_decoder_unit.sv
`timescale 1ns / 1ps

// Fixed-length frame receiver. Takes one input transfer per clock: a received
// byte, a line-error event or a poll. Payload bytes of the frame being built
// go straight into one bank of a two-bank payload memory; an accepted frame
// just swaps the bank pointers, so no copy is needed and the next frame can
// start on the following cycle. A poll reads the latched bank as a whole row
// and its result transfer appears in the next cycle, from the memory's output
// register. Bytes and line errors keep flowing while a result waits; a poll
// waits (stall high) only while the previous result has not been taken. The
// memory needs no clearing pass after reset.
module fixed_frame_receiver_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        packet_found,
    output logic [31:0] arm_pitch_bits,
    output logic [31:0] arm_roll_bits,
    output logic [31:0] arm_yaw_bits,
    output logic [31:0] elbow_roll_bits,
    output logic [31:0] elbow_yaw_bits,
    output logic [31:0] wrist_roll_bits,
    output logic [15:0] claw_value,
    output logic [15:0] error_total,
    output logic [15:0] overwrite_total
);
    import ffrd_pkg::*;

    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LENGTH - 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_LENGTH);
    localparam logic [POS_W-1:0] POS_PAY   = POS_W'(PAYLOAD_FIRST);

    logic [7:0] start_reg;
    logic [7:0] type_reg;
    logic [7:0] end_reg;

    logic               in_frame_reg,  in_frame_next;
    logic [POS_W-1:0]   pos_reg,       pos_next;
    logic [7:0]         byte0_reg,     byte0_next;
    logic [7:0]         byte1_reg,     byte1_next;
    logic               pending_reg,   pending_next;
    logic [BANK_W-1:0]  wr_bank_reg,   wr_bank_next;
    logic [BANK_W-1:0]  lat_bank_reg,  lat_bank_next;
    logic [TALLY_W-1:0] err_reg,       err_next;
    logic [TALLY_W-1:0] ovw_reg,       ovw_next;
    logic               out_valid_reg, out_valid_next;
    logic               has_reg,       has_next;
    logic [TALLY_W-1:0] err_out_reg,   err_out_next;
    logic [TALLY_W-1:0] ovw_out_reg,   ovw_out_next;

    cmd_t     cmd;
    logic     in_fire;
    logic     poll_fire;
    mem_wr_t  mem_wr;
    mem_rd_t  mem_rd;
    payload_t row;

    assign cmd       = cmd_t'(command);
    assign in_stall  = out_valid_reg && out_stall && (cmd == CMD_POLL);
    assign in_fire   = in_valid && !in_stall;
    assign poll_fire = in_fire && (cmd == CMD_POLL);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_BYTE_RESET;
            type_reg  <= TYPE_BYTE_RESET;
            end_reg   <= END_BYTE_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_START: start_reg <= cfg_data;
                REG_TYPE:  type_reg  <= cfg_data;
                REG_END:   end_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        pos_next       = pos_reg;
        byte0_next     = byte0_reg;
        byte1_next     = byte1_reg;
        pending_next   = pending_reg;
        wr_bank_next   = wr_bank_reg;
        lat_bank_next  = lat_bank_reg;
        err_next       = err_reg;
        ovw_next       = ovw_reg;
        has_next       = has_reg;
        err_out_next   = err_out_reg;
        ovw_out_next   = ovw_out_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_wr.en      = 1'b0;
        mem_wr.bank    = wr_bank_reg;
        mem_wr.lane    = LANE_W'(pos_reg - POS_PAY);
        mem_wr.data    = rx_byte;
        mem_rd.en      = 1'b0;
        mem_rd.bank    = lat_bank_reg;

        if (in_fire)
        begin
            unique case (cmd)
                CMD_BYTE:
                begin
                    if (!in_frame_reg)
                    begin
                        if (rx_byte == start_reg)
                        begin
                            byte0_next    = rx_byte;
                            pos_next      = POS_FIRST;
                            in_frame_next = 1'b1;
                        end
                    end
                    else if (pos_reg >= POS_LIMIT)
                    begin
                        err_next      = (err_reg == '1) ? err_reg : err_reg + 1'b1;
                        in_frame_next = 1'b0;
                        pos_next      = '0;
                    end
                    else if (pos_reg == POS_FIRST)
                    begin
                        byte1_next = rx_byte;
                        if (rx_byte != type_reg)
                        begin
                            err_next      = (err_reg == '1) ? err_reg : err_reg + 1'b1;
                            in_frame_next = 1'b0;
                            pos_next      = '0;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                    else if (pos_reg == POS_LAST)
                    begin
                        if (byte0_reg == start_reg && byte1_reg == type_reg &&
                            rx_byte == end_reg)
                        begin
                            if (pending_reg)
                            begin
                                ovw_next = (ovw_reg == '1) ? ovw_reg : ovw_reg + 1'b1;
                            end
                            pending_next  = 1'b1;
                            lat_bank_next = wr_bank_reg;
                            wr_bank_next  = wr_bank_reg + 1'b1;
                        end
                        else
                        begin
                            err_next = (err_reg == '1) ? err_reg : err_reg + 1'b1;
                        end
                        in_frame_next = 1'b0;
                        pos_next      = '0;
                    end
                    else
                    begin
                        mem_wr.en = 1'b1;
                        pos_next  = pos_reg + 1'b1;
                    end
                end
                CMD_LINE_ERR:
                begin
                    err_next      = (err_reg == '1) ? err_reg : err_reg + 1'b1;
                    in_frame_next = 1'b0;
                    pos_next      = '0;
                end
                CMD_POLL:
                begin
                    mem_rd.en      = 1'b1;
                    has_next       = pending_reg;
                    err_out_next   = err_reg;
                    ovw_out_next   = ovw_reg;
                    out_valid_next = 1'b1;
                    pending_next   = 1'b0;
                    err_next       = '0;
                    ovw_next       = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            pos_reg       <= '0;
            pending_reg   <= 1'b0;
            wr_bank_reg   <= '0;
            lat_bank_reg  <= '0;
            err_reg       <= '0;
            ovw_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            pos_reg       <= pos_next;
            pending_reg   <= pending_next;
            wr_bank_reg   <= wr_bank_next;
            lat_bank_reg  <= lat_bank_next;
            err_reg       <= err_next;
            ovw_reg       <= ovw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte0_reg   <= byte0_next;
        byte1_reg   <= byte1_next;
        has_reg     <= has_next;
        err_out_reg <= err_out_next;
        ovw_out_reg <= ovw_out_next;
    end

    ffrd_payload_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (row)
    );

    // big-endian: lane 0 is frame byte 2
    assign out_valid       = out_valid_reg;
    assign packet_found    = has_reg;
    assign arm_pitch_bits  = has_reg ? {row[0],  row[1],  row[2],  row[3]}  : '0;
    assign arm_roll_bits   = has_reg ? {row[4],  row[5],  row[6],  row[7]}  : '0;
    assign arm_yaw_bits    = has_reg ? {row[8],  row[9],  row[10], row[11]} : '0;
    assign elbow_roll_bits = has_reg ? {row[12], row[13], row[14], row[15]} : '0;
    assign elbow_yaw_bits  = has_reg ? {row[16], row[17], row[18], row[19]} : '0;
    assign wrist_roll_bits = has_reg ? {row[20], row[21], row[22], row[23]} : '0;
    assign claw_value      = has_reg ? {row[24], row[25]} : '0;
    assign error_total     = err_out_reg;
    assign overwrite_total = ovw_out_reg;

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (pos_reg >= POS_FIRST && pos_reg <= POS_LAST))
        else $error("byte position out of range inside a frame");

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (pos_reg == '0))
        else $error("byte position not cleared outside a frame");

    a_poll_result: assert property (@(posedge clk) disable iff (!rst_n)
        poll_fire |=> (out_valid && !pending_reg && err_reg == '0 && ovw_reg == '0))
        else $error("poll did not produce a result and clear state");

    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg && mem_wr.en) |-> (mem_wr.bank != lat_bank_reg))
        else $error("frame write hit the latched bank");

endmodule

### sim/frame_decode_checker.sv
`timescale 1ns / 1ps

module frame_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  command,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        packet_found,
    input  logic [31:0] arm_pitch_bits,
    input  logic [31:0] arm_roll_bits,
    input  logic [31:0] arm_yaw_bits,
    input  logic [31:0] elbow_roll_bits,
    input  logic [31:0] elbow_yaw_bits,
    input  logic [31:0] wrist_roll_bits,
    input  logic [15:0] claw_value,
    input  logic [15:0] error_total,
    input  logic [15:0] overwrite_total,
    output int          fail_count,
    output int          pending_results
);
    import ffrd_pkg::*;

    typedef struct packed {
        logic               found;
        logic [31:0]        arm_pitch;
        logic [31:0]        arm_roll;
        logic [31:0]        arm_yaw;
        logic [31:0]        elbow_roll;
        logic [31:0]        elbow_yaw;
        logic [31:0]        wrist_roll;
        logic [15:0]        claw;
        logic [TALLY_W-1:0] errors;
        logic [TALLY_W-1:0] overwrites;
    } poll_result_t;

    poll_result_t due_q[$];

    logic [7:0]         start_r;
    logic [7:0]         type_r;
    logic [7:0]         end_r;
    logic               framing;
    logic [POS_W-1:0]   fill_pos;
    logic [7:0]         frame_buf [FRAME_LENGTH];
    logic [7:0]         latched [PAYLOAD_COUNT];
    logic               pkt_pending;
    logic [TALLY_W-1:0] err_tally;
    logic [TALLY_W-1:0] ovw_tally;

    function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [31:0] latched_word(input int base);
        return {latched[base], latched[base+1], latched[base+2], latched[base+3]};
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic drop_frame();
        framing  = 1'b0;
        fill_pos = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int i;
        if (!framing) begin
            if (b == start_r) begin
                frame_buf[0] = b;
                fill_pos     = POS_W'(1);
                framing      = 1'b1;
            end
        end
        else if (fill_pos >= FRAME_LENGTH) begin
            err_tally = bump(err_tally);
            drop_frame();
        end
        else begin
            frame_buf[fill_pos] = b;
            fill_pos            = fill_pos + 1'b1;
            if (fill_pos == 2) begin
                if (frame_buf[1] != type_r) begin
                    err_tally = bump(err_tally);
                    drop_frame();
                end
            end
            else if (fill_pos == FRAME_LENGTH) begin
                // register values at completion time decide acceptance
                if (frame_buf[0] == start_r && frame_buf[1] == type_r &&
                    frame_buf[FRAME_LENGTH-1] == end_r) begin
                    if (pkt_pending)
                        ovw_tally = bump(ovw_tally);
                    for (i = 0; i < PAYLOAD_COUNT; i++)
                        latched[i] = frame_buf[PAYLOAD_FIRST+i];
                    pkt_pending = 1'b1;
                end
                else begin
                    err_tally = bump(err_tally);
                end
                drop_frame();
            end
        end
    endtask

    task automatic take_poll();
        poll_result_t r;
        r.found      = pkt_pending;
        r.arm_pitch  = pkt_pending ? latched_word(0)  : '0;
        r.arm_roll   = pkt_pending ? latched_word(4)  : '0;
        r.arm_yaw    = pkt_pending ? latched_word(8)  : '0;
        r.elbow_roll = pkt_pending ? latched_word(12) : '0;
        r.elbow_yaw  = pkt_pending ? latched_word(16) : '0;
        r.wrist_roll = pkt_pending ? latched_word(20) : '0;
        r.claw       = pkt_pending ? {latched[24], latched[25]} : '0;
        r.errors     = err_tally;
        r.overwrites = ovw_tally;
        due_q.push_back(r);
        pkt_pending = 1'b0;
        err_tally   = '0;
        ovw_tally   = '0;
    endtask

    task automatic compare_result();
        poll_result_t want;
        if (due_q.size() == 0) begin
            report_mismatch("result transfer with no poll outstanding");
        end
        else begin
            want = due_q.pop_front();
            check_field("packet_found", 32'(packet_found), 32'(want.found));
            check_field("arm_pitch_bits", arm_pitch_bits, want.arm_pitch);
            check_field("arm_roll_bits", arm_roll_bits, want.arm_roll);
            check_field("arm_yaw_bits", arm_yaw_bits, want.arm_yaw);
            check_field("elbow_roll_bits", elbow_roll_bits, want.elbow_roll);
            check_field("elbow_yaw_bits", elbow_yaw_bits, want.elbow_yaw);
            check_field("wrist_roll_bits", wrist_roll_bits, want.wrist_roll);
            check_field("claw_value", 32'(claw_value), 32'(want.claw));
            check_field("error_total", 32'(error_total), 32'(want.errors));
            check_field("overwrite_total", 32'(overwrite_total),
                        32'(want.overwrites));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        int i;
        if (!rst_n) begin
            start_r     = START_BYTE_RESET;
            type_r      = TYPE_BYTE_RESET;
            end_r       = END_BYTE_RESET;
            framing     = 1'b0;
            fill_pos    = '0;
            for (i = 0; i < FRAME_LENGTH; i++)
                frame_buf[i] = '0;
            for (i = 0; i < PAYLOAD_COUNT; i++)
                latched[i] = '0;
            pkt_pending = 1'b0;
            err_tally   = '0;
            ovw_tally   = '0;
            due_q.delete();
        end
        else begin
            // a result transfer here belongs to an earlier poll
            if (out_valid && !out_stall)
                compare_result();
            if (in_valid && !in_stall) begin
                case (command)
                    CMD_BYTE:     absorb_byte(rx_byte);
                    CMD_LINE_ERR: begin
                        err_tally = bump(err_tally);
                        drop_frame();
                    end
                    CMD_POLL:     take_poll();
                    default:      ;
                endcase
            end
            // a register write takes effect after this edge
            if (cfg_we) begin
                case (cfg_index)
                    REG_START: start_r = cfg_data;
                    REG_TYPE:  type_r  = cfg_data;
                    REG_END:   end_r   = cfg_data;
                    default:   ;
                endcase
            end
        end
        pending_results = due_q.size();
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import ffrd_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_ZERO    = 1;
    localparam int FILL_ONES    = 2;
    localparam int NO_POLL      = -1;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 115;
    localparam int PHASE_POLLS  = 6;
    localparam int ERR_BURST    = 40;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } xfer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = CMD_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_START;
    logic [7:0]  cfg_data = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        packet_found;
    logic [31:0] arm_pitch_bits;
    logic [31:0] arm_roll_bits;
    logic [31:0] arm_yaw_bits;
    logic [31:0] elbow_roll_bits;
    logic [31:0] elbow_yaw_bits;
    logic [31:0] wrist_roll_bits;
    logic [15:0] claw_value;
    logic [15:0] error_total;
    logic [15:0] overwrite_total;
    int          fail_count;
    int          pending_results;

    xfer_t       plan_q[$];
    int          polls_planned;
    int          idle_pct;
    int          stall_pct;
    int          quiet_cycles;
    logic [7:0]  cur_start;
    logic [7:0]  cur_type;
    logic [7:0]  cur_end;

    fixed_frame_receiver_decoder_unit dut (.*);

    frame_decode_checker checker_i (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ends the run when no transfer moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void add_xfer(input logic [1:0] c, input logic [7:0] b);
        xfer_t x;
        x.cmd  = c;
        x.data = b;
        plan_q.push_back(x);
        if (c == CMD_POLL)
            polls_planned++;
    endfunction

    function automatic logic [7:0] fill_byte(input int fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] v);
        return v ^ 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_frame(input logic [7:0] s, input logic [7:0] t,
                                      input logic [7:0] e, input int fill,
                                      input int poll_slot);
        add_xfer(CMD_BYTE, s);
        add_xfer(CMD_BYTE, t);
        for (int i = 0; i < PAYLOAD_COUNT; i++) begin
            if (i == poll_slot)
                add_xfer(CMD_POLL, 8'($urandom));
            add_xfer(CMD_BYTE, fill_byte(fill));
        end
        add_xfer(CMD_BYTE, e);
    endfunction

    function automatic void add_random_burst();
        int r;
        int f;
        r = $urandom_range(99);
        if (r < 45) begin
            case ($urandom_range(9))
                0:       f = FILL_ONES;
                1:       f = FILL_ZERO;
                default: f = FILL_RANDOM;
            endcase
            add_frame(cur_start, cur_type, cur_end, f, NO_POLL);
            if ($urandom_range(99) < 30)
                add_xfer(CMD_POLL, 8'($urandom));
        end
        else if (r < 53) begin
            add_frame(cur_start, other_than(cur_type), cur_end, FILL_RANDOM, NO_POLL);
        end
        else if (r < 61) begin
            add_frame(cur_start, cur_type, other_than(cur_end), FILL_RANDOM, NO_POLL);
        end
        else if (r < 68) begin
            add_xfer(CMD_BYTE, cur_start);
            if ($urandom_range(3) != 0) begin
                add_xfer(CMD_BYTE, cur_type);
                repeat ($urandom_range(0, PAYLOAD_COUNT))
                    add_xfer(CMD_BYTE, 8'($urandom));
            end
            add_xfer(CMD_LINE_ERR, 8'($urandom));
        end
        else if (r < 74) begin
            add_frame(cur_start, cur_type, cur_end, FILL_RANDOM,
                      $urandom_range(0, PAYLOAD_COUNT - 1));
        end
        else if (r < 88) begin
            add_xfer(CMD_POLL, 8'($urandom));
        end
        else if (r < 94) begin
            repeat ($urandom_range(1, 4))
                add_xfer(CMD_BYTE, 8'($urandom));
        end
        else if (r < 97) begin
            add_xfer(CMD_UNUSED, 8'($urandom));
        end
        else begin
            add_xfer(CMD_LINE_ERR, 8'($urandom));
        end
    endfunction

    task automatic play_plan();
        xfer_t x;
        bit    took;
        while (plan_q.size() > 0) begin
            x = plan_q.pop_front();
            while ($urandom_range(99) < idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            command  <= x.cmd;
            rx_byte  <= x.data;
            do begin
                @(negedge clk);
                took = !in_stall;
                @(posedge clk);
            end while (!took);
        end
        in_valid <= 1'b0;
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_START: cur_start = v;
            REG_TYPE:  cur_type  = v;
            REG_END:   cur_end   = v;
            default:   ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] s, input logic [7:0] t,
                                input logic [7:0] e);
        write_reg(REG_START, s);
        write_reg(REG_TYPE, t);
        write_reg(REG_END, e);
    endtask

    task automatic set_mode(input int m);
        case (m)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 47; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 15; stall_pct = 15; end
        endcase
    endtask

    initial
    begin
        int p;
        cur_start = START_BYTE_RESET;
        cur_type  = TYPE_BYTE_RESET;
        cur_end   = END_BYTE_RESET;
        set_mode(0);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: empty poll, ignored command, line error, bad type,
        // good frames with overwrite, bad end byte, interrupted frames
        add_xfer(CMD_POLL, 8'h00);
        add_xfer(CMD_UNUSED, START_BYTE_RESET);
        add_xfer(CMD_UNUSED, 8'hFF);
        add_xfer(CMD_LINE_ERR, 8'hFF);
        add_xfer(CMD_POLL, 8'hFF);
        add_xfer(CMD_BYTE, cur_start);
        add_xfer(CMD_BYTE, other_than(cur_type));
        add_xfer(CMD_BYTE, 8'h00);
        add_frame(cur_start, cur_type, cur_end, FILL_ONES, NO_POLL);
        add_frame(cur_start, cur_type, cur_end, FILL_ZERO, NO_POLL);
        add_xfer(CMD_POLL, 8'h00);
        add_frame(cur_start, cur_type, cur_end, FILL_RANDOM, NO_POLL);
        add_frame(cur_start, cur_type, other_than(cur_end), FILL_RANDOM, NO_POLL);
        add_xfer(CMD_POLL, 8'h5A);
        add_xfer(CMD_BYTE, cur_start);
        add_xfer(CMD_BYTE, cur_type);
        repeat (5) add_xfer(CMD_BYTE, 8'($urandom));
        add_xfer(CMD_LINE_ERR, 8'h00);
        add_frame(cur_start, cur_type, cur_end, FILL_RANDOM, 10);
        add_xfer(CMD_POLL, 8'hA5);
        play_plan();
        settle();

        // end byte changed mid-frame: new value must close the frame
        add_xfer(CMD_BYTE, cur_start);
        add_xfer(CMD_BYTE, cur_type);
        repeat (12) add_xfer(CMD_BYTE, 8'($urandom));
        play_plan();
        settle();
        write_reg(REG_END, 8'h00);
        repeat (14) add_xfer(CMD_BYTE, 8'($urandom));
        add_xfer(CMD_BYTE, cur_end);
        add_xfer(CMD_POLL, 8'h00);
        play_plan();
        settle();

        // start byte changed mid-frame: completed frame no longer matches
        add_xfer(CMD_BYTE, cur_start);
        add_xfer(CMD_BYTE, cur_type);
        repeat (12) add_xfer(CMD_BYTE, 8'($urandom));
        play_plan();
        settle();
        write_reg(REG_START, other_than(cur_start));
        repeat (14) add_xfer(CMD_BYTE, 8'($urandom));
        add_xfer(CMD_BYTE, cur_end);
        add_xfer(CMD_POLL, 8'h00);
        play_plan();
        settle();

        // line error burst
        repeat (ERR_BURST) add_xfer(CMD_LINE_ERR, 8'($urandom));
        add_xfer(CMD_POLL, 8'h00);
        add_xfer(CMD_LINE_ERR, 8'h00);
        add_xfer(CMD_POLL, 8'hFF);
        play_plan();
        settle();

        for (p = 0; p < PHASES; p++) begin
            if (p == 0)
                program_regs(8'h00, 8'h00, 8'h00);
            else if (p == 1)
                program_regs(8'hFF, 8'hFF, 8'hFF);
            else
                program_regs(pick_reg_value(), pick_reg_value(), pick_reg_value());
            set_mode(p % 4);
            polls_planned = 0;
            while (plan_q.size() < PHASE_ITEMS || polls_planned < PHASE_POLLS)
                add_random_burst();
            play_plan();
            settle();
        end

        if (fail_count == 0 && pending_results == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
